[src/swph_pkg.sv]
// package for the sequence window packet history
// types, constants and state codes used by the top level; the record ram does not import them
// no dependencies
package swph_pkg;

  localparam int HIST_DEPTH = 2048;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int SEQ_W      = 16;
  localparam int SIZE_W     = 16;
  localparam int TIME_W     = 63;
  localparam int MEDIA_W    = 2;
  localparam int COUNT_W    = 12;

  localparam logic [SEQ_W-1:0] FULL_SPAN = SEQ_W'(HIST_DEPTH - 1);

  localparam logic CMD_SAVE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_WRITE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               command;
    logic [SEQ_W-1:0]   seq_number;
    logic [SIZE_W-1:0]  padding_bytes;
    logic [SIZE_W-1:0]  payload_bytes;
    logic [SIZE_W-1:0]  generated_bytes;
    logic [SIZE_W-1:0]  encrypted_bytes;
    logic [TIME_W-1:0]  send_time_us;
    logic [MEDIA_W-1:0] media_kind;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [SEQ_W-1:0]   rec_seq;
    logic [SIZE_W-1:0]  rec_padding;
    logic [SIZE_W-1:0]  rec_payload;
    logic [SIZE_W-1:0]  rec_generated;
    logic [SIZE_W-1:0]  rec_encrypted;
    logic [TIME_W-1:0]  rec_send_time;
    logic [MEDIA_W-1:0] rec_media;
    logic [COUNT_W-1:0] window_count;
  } response_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [SIZE_W-1:0]  padding;
    logic [SIZE_W-1:0]  payload;
    logic [SIZE_W-1:0]  generated;
    logic [SIZE_W-1:0]  encrypted;
    logic [TIME_W-1:0]  send_time;
    logic [MEDIA_W-1:0] media;
  } record_t;

  localparam int REC_W = $bits(record_t);

endpackage

[src/swph_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module swph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sequence_window_packet_history.sv]
// top level of the sequence window packet history: window sequencer and record ring
// depends on swph_pkg and swph_ram
//
// channel   signals                  handshake
// request   start, busy, request     beat taken when start is high and busy is low
// response  done, response           beat shown for one cycle while done is high
//
// a query reads the ram when taken; its response is registered from the resp state
// a save loops in the step state until the newest number reaches it, then writes;
// the step loop clears one ring slot per cycle through the single ram write port,
// so a save of the newest number again loops round the whole sequence number space
// the first save opens the window and writes at once; reset needs no clearing pass
// the receiver cannot stall: each response is shown once and busy stays high
// until the result is registered
module sequence_window_packet_history (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  swph_pkg::request_t  request,
  output logic                busy,
  output logic                done,
  output swph_pkg::response_t response
);
  import swph_pkg::*;

  state_t    state, state_next;
  logic      started, started_next;
  logic [SEQ_W-1:0] oldest, oldest_next;
  logic [SEQ_W-1:0] newest, newest_next;
  request_t  item, item_next;
  logic      hit, hit_next;
  logic      done_next;
  response_t response_next;

  logic              accept;
  logic [SEQ_W-1:0]  span;
  logic [SEQ_W-1:0]  offset;
  logic [SEQ_W-1:0]  step_seq;
  logic [COUNT_W-1:0] count;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  record_t           ram_wdata;
  record_t           ram_rdata;
  logic [REC_W-1:0]  ram_rbits;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign span     = newest - oldest;
  assign offset   = request.seq_number - oldest;
  assign step_seq = newest + SEQ_W'(1);
  assign count    = started ? COUNT_W'(span + SEQ_W'(1)) : '0;
  assign ram_rdata = record_t'(ram_rbits);

  swph_ram #(
    .WIDTH(REC_W),
    .DEPTH(HIST_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(REC_W'(ram_wdata)),
    .re   (accept),
    .raddr(request.seq_number[SLOT_W-1:0]),
    .rdata(ram_rbits)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (request.command == CMD_SAVE) begin
            state_next = started ? ST_STEP : ST_WRITE;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_STEP: begin
        if (step_seq == item.seq_number) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    started_next  = started;
    oldest_next   = oldest;
    newest_next   = newest;
    item_next     = item;
    hit_next      = hit;
    done_next     = 1'b0;
    response_next = response;
    ram_we        = 1'b0;
    ram_waddr     = item.seq_number[SLOT_W-1:0];
    ram_wdata     = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          item_next = request;
          hit_next  = started && (offset <= span);
          if (request.command == CMD_SAVE && !started) begin
            started_next = 1'b1;
            oldest_next  = request.seq_number;
            newest_next  = request.seq_number;
          end
        end
      end
      ST_STEP: begin
        if (span == FULL_SPAN) begin
          oldest_next = oldest + SEQ_W'(1);
        end
        newest_next = step_seq;
        ram_we      = 1'b1;
        ram_waddr   = step_seq[SLOT_W-1:0];
      end
      ST_WRITE: begin
        ram_we              = 1'b1;
        ram_wdata.seq       = item.seq_number;
        ram_wdata.padding   = item.padding_bytes;
        ram_wdata.payload   = item.payload_bytes;
        ram_wdata.generated = item.generated_bytes;
        ram_wdata.encrypted = item.encrypted_bytes;
        ram_wdata.send_time = item.send_time_us;
        ram_wdata.media     = item.media_kind;
        done_next           = 1'b1;
        response_next       = '0;
        response_next.window_count = count;
      end
      ST_RESP: begin
        done_next     = 1'b1;
        response_next = '0;
        if (hit) begin
          response_next.found         = 1'b1;
          response_next.rec_seq       = ram_rdata.seq;
          response_next.rec_padding   = ram_rdata.padding;
          response_next.rec_payload   = ram_rdata.payload;
          response_next.rec_generated = ram_rdata.generated;
          response_next.rec_encrypted = ram_rdata.encrypted;
          response_next.rec_send_time = ram_rdata.send_time;
          response_next.rec_media     = ram_rdata.media;
        end
        response_next.window_count = count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
      oldest  <= '0;
      newest  <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
      oldest  <= oldest_next;
      newest  <= newest_next;
      done    <= done_next;
    end
    item     <= item_next;
    hit      <= hit_next;
    response <= response_next;
  end

endmodule
